### rtl/mt_pkg.sv
// Shared constants and types for the MT19937 generator.
// Used by the state memory, the twist/temper datapath and the top level.
// No dependencies.
`default_nettype none

package mt_pkg;

  localparam int WORD_W      = 32;
  localparam int STATE_WORDS = 624;
  localparam int SHIFT_AHEAD = 397;
  localparam int ADDR_W      = $clog2(STATE_WORDS);

  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W-1:0] AHEAD_OFS  = ADDR_W'(SHIFT_AHEAD);
  localparam logic [ADDR_W-1:0] AHEAD_WRAP = ADDR_W'(STATE_WORDS - SHIFT_AHEAD);

  localparam logic [WORD_W-1:0] MATRIX_A  = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] INIT_MULT = 32'd1812433253;

  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_DRAW
  } mt_state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } mt_ram_wr_t;

endpackage

`default_nettype wire

### rtl/mt_ram.sv
// State word memory: one write port and two registered read ports.
// Depends on mt_pkg for the depth, widths and the write port type.
`default_nettype none

module mt_ram (
  input  logic                     clk,
  input  mt_pkg::mt_ram_wr_t       wr,
  input  logic                     rd_en,
  input  logic [mt_pkg::ADDR_W-1:0] rd_addr_a,
  input  logic [mt_pkg::ADDR_W-1:0] rd_addr_b,
  output logic [mt_pkg::WORD_W-1:0] rd_data_a,
  output logic [mt_pkg::WORD_W-1:0] rd_data_b
);
  import mt_pkg::*;

  logic [WORD_W-1:0] mem [STATE_WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

### rtl/mt_twist.sv
// Per-word twist of one state word followed by output tempering.
// Depends on mt_pkg for the matrix and tempering constants.
`default_nettype none

module mt_twist (
  input  logic [mt_pkg::WORD_W-1:0] cur_word,
  input  logic [mt_pkg::WORD_W-1:0] next_word,
  input  logic [mt_pkg::WORD_W-1:0] ahead_word,
  output logic [mt_pkg::WORD_W-1:0] new_word,
  output logic [mt_pkg::WORD_W-1:0] tempered
);
  import mt_pkg::*;

  logic [WORD_W-1:0] merged;
  logic [WORD_W-1:0] shifted;
  logic [WORD_W-1:0] t1;
  logic [WORD_W-1:0] t2;
  logic [WORD_W-1:0] t3;

  always_comb begin
    merged   = {cur_word[WORD_W-1], next_word[WORD_W-2:0]};
    shifted  = (merged >> 1) ^ (merged[0] ? MATRIX_A : '0);
    new_word = ahead_word ^ shifted;
    t1       = new_word ^ (new_word >> 11);
    t2       = t1 ^ ((t1 << 7) & TEMPER_B);
    t3       = t2 ^ ((t2 << 15) & TEMPER_C);
    tempered = t3 ^ (t3 >> 18);
  end

endmodule

`default_nettype wire

### rtl/mersenne_twister_prng.sv
// Top level of the MT19937 generator: command sequencer, seeding multiplier and output register.
// Depends on mt_pkg, mt_ram and mt_twist.
//
//   channel | direction | tdata            | tuser
//   in_     | slave     | seed_value[31:0] | cmd (0 seed, 1 next)
//   out_    | master    | random_value     | not_seeded
//
// A draw: the accept cycle reads two state words; the draw state, once no result is held,
// twists one word in place, tempers it and loads the output register (zero if unseeded).
// A seed writes the seed word, then 623 words, each by a multiply step then an add-and-write step.
// The memory content is undefined after reset; the index and the seeded flag are cleared.
// in_tready is high only between commands; a held result does not block accepting one.
`default_nettype none

module mersenne_twister_prng (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,   // seed_value[31:0]
  input  logic                      in_tuser,   // cmd
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata,  // random_value[31:0]
  output logic                      out_tuser   // not_seeded
);
  import mt_pkg::*;

  mt_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic              seeded_r, seeded_nxt;
  logic [WORD_W-1:0] cur_r, cur_nxt;
  logic [WORD_W-1:0] prev_r, prev_nxt;
  logic [WORD_W-1:0] prod_r, prod_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;
  logic              out_flag_r, out_flag_nxt;

  mt_ram_wr_t        wr;
  logic              rd_en;
  logic [ADDR_W-1:0] addr_next;
  logic [ADDR_W-1:0] addr_ahead;
  logic [WORD_W-1:0] rd_data_a;
  logic [WORD_W-1:0] rd_data_b;
  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] tempered;
  logic [WORD_W-1:0] seed_word;
  logic              in_accept;
  logic              out_free;

  mt_ram u_ram (
    .clk       (clk),
    .wr        (wr),
    .rd_en     (rd_en),
    .rd_addr_a (addr_next),
    .rd_addr_b (addr_ahead),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  mt_twist u_twist (
    .cur_word   (cur_r),
    .next_word  (rd_data_a),
    .ahead_word (rd_data_b),
    .new_word   (new_word),
    .tempered   (tempered)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;
  assign out_free   = !out_valid_r || out_tready;

  assign addr_next  = (idx_r == LAST_ADDR) ? '0 : idx_r + ADDR_W'(1);
  assign addr_ahead = (idx_r >= AHEAD_WRAP) ? idx_r - AHEAD_WRAP : idx_r + AHEAD_OFS;
  assign seed_word  = prod_r + WORD_W'(k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      k_r         <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
    out_flag_r <= out_flag_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    seeded_nxt    = seeded_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_flag_nxt  = out_flag_r;
    wr            = '0;
    rd_en         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_tuser == CMD_SEED) begin
            wr.en      = 1'b1;
            wr.addr    = '0;
            wr.data    = in_tdata;
            prev_nxt   = in_tdata;
            cur_nxt    = in_tdata;
            k_nxt      = ADDR_W'(1);
            idx_nxt    = '0;
            seeded_nxt = 1'b1;
            state_nxt  = ST_SEED_MUL;
          end else begin
            rd_en     = 1'b1;
            state_nxt = ST_DRAW;
          end
        end
      end
      ST_SEED_MUL: begin
        prod_nxt  = INIT_MULT * (prev_r ^ (prev_r >> 30));
        state_nxt = ST_SEED_WR;
      end
      ST_SEED_WR: begin
        wr.en    = 1'b1;
        wr.addr  = k_r;
        wr.data  = seed_word;
        prev_nxt = seed_word;
        if (k_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          k_nxt     = k_r + ADDR_W'(1);
          state_nxt = ST_SEED_MUL;
        end
      end
      ST_DRAW: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (seeded_r) begin
            wr.en        = 1'b1;
            wr.addr      = idx_r;
            wr.data      = new_word;
            cur_nxt      = rd_data_a;
            idx_nxt      = addr_next;
            out_data_nxt = tempered;
            out_flag_nxt = 1'b0;
          end else begin
            out_data_nxt = '0;
            out_flag_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_unseeded_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("Unseeded result carries a non-zero word.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("Input accepted again before the previous command finished.");

  a_no_write_unseeded: assert property (@(posedge clk) disable iff (!rst_n)
    !seeded_r |-> !wr.en || (state_r == ST_IDLE))
    else $error("State memory written before any seed.");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_ADDR && k_r <= LAST_ADDR)
    else $error("State index beyond the memory.");

  a_result_on_draw: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAW && out_free |=> out_tvalid && state_r == ST_IDLE)
    else $error("Draw finished without a result.");
`endif

endmodule

`default_nettype wire
